// File: rtl/core/mpa_pkg.sv
`default_nettype none
package mpa_pkg;

  // Register indexes of the configuration port.
  localparam logic [7:0] REG_POOL_SIZE    = 8'd0;
  localparam logic [7:0] REG_STRIDE       = 8'd1;
  localparam logic [7:0] REG_PLANE_HEIGHT = 8'd2;
  localparam logic [7:0] REG_PLANE_WIDTH  = 8'd3;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 11;
  localparam int POOL_W    = 4;
  localparam int DIM_W     = 11;
  localparam int POS_W     = 10;
  localparam int PLANE_W   = 16;

  localparam logic [POOL_W-1:0] POOL_RESET   = 4'd2;
  localparam logic [POOL_W-1:0] STRIDE_RESET = 4'd2;
  localparam logic [DIM_W-1:0]  DIM_RESET    = 11'd32;

endpackage
`default_nettype wire

// File: rtl/core/mpa_ram.sv
`default_nettype none
module mpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mpa_cell.sv
`default_nettype none
module mpa_cell #(
  parameter int DW  = 16,
  parameter int PW  = 3,
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  shift,
  input  wire logic [3:0]            pool,
  input  wire logic signed [DW-1:0]  in_val,
  input  wire logic [PW-1:0]         in_row,
  output logic signed [DW-1:0]       val,
  output logic [PW-1:0]              row,
  input  wire logic                  acc_hit_in,
  input  wire logic signed [DW-1:0]  acc_val_in,
  input  wire logic [PW-1:0]         acc_row_in,
  input  wire logic [PW-1:0]         acc_col_in,
  output logic                       acc_hit_out,
  output logic signed [DW-1:0]       acc_val_out,
  output logic [PW-1:0]              acc_row_out,
  output logic [PW-1:0]              acc_col_out
);

  // Each cell holds the best sample of one window column and the row
  // (counted back from the newest) where it sits.
  always_ff @(posedge clk) begin
    if (shift) begin
      val <= in_val;
      row <= in_row;
    end
  end

  logic take;

  // Older columns come first in the chain; a later column wins only when
  // strictly larger, or equal and in an earlier row.
  always_comb begin
    take = 1'b0;
    if (IDX < int'(pool)) begin
      take = !acc_hit_in || (val > acc_val_in) ||
             ((val == acc_val_in) && (row > acc_row_in));
    end
    acc_hit_out = acc_hit_in || take;
    acc_val_out = take ? val : acc_val_in;
    acc_row_out = take ? row : acc_row_in;
    acc_col_out = take ? PW'(IDX) : acc_col_in;
  end

endmodule
`default_nettype wire

// File: rtl/core/max_pool_2d_argmax.sv
`default_nettype none
// Streaming 2-D max pooling with argmax.
// Pixels enter on the s_ stream in raster order, one request per pixel,
// plane after plane. Whenever a pixel completes a pool window whose origin
// lies on the stride grid, one result request leaves on the m_ stream with
// the window maximum, its input row and column, the plane number and the
// output row and column of the window. Ties go to the earliest pixel in
// raster order.
// The cfg_ port writes the window size, stride, plane height and plane
// width; a write to one of these registers restarts the position in the
// plane and keeps the plane number.
// Throughput is one pixel per cycle while the receiver does not stall.
// The line store is read at the edge that takes a pixel; the column
// reduction is registered in stage 2, the cell chain shifts together with
// stage 3, and the chain reduction is registered in the output register.
// Reset restores the register defaults (2, 2, 32, 32) and clears all
// counters; the line store is not cleared, since a window only ever uses
// pixels of the current plane.
// When the receiver stalls the whole pipeline holds, and s_tready drops
// while a result waits in the output register.
module max_pool_2d_argmax #(
  parameter int MAX_POOL   = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  // s_tdata: pixel_value
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
  // m_tdata: max_value, arg_row, arg_col, plane_number, out_row, out_col
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [((DATA_WIDTH+56+7)/8)*8-1:0]         m_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [mpa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mpa_pkg::CFG_DAT_W-1:0]         cfg_data
);

  localparam int LINE_ROWS = MAX_POOL - 1;
  localparam int SW  = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int PW  = $clog2(MAX_POOL);
  localparam int DW  = DATA_WIDTH;
  localparam int OTW = ((DATA_WIDTH + 56 + 7) / 8) * 8;
  localparam int PSW = mpa_pkg::POS_W;

  // Configuration.
  logic [mpa_pkg::POOL_W-1:0] win_size, stride;
  logic [mpa_pkg::DIM_W-1:0]  plane_height, plane_width;
  logic                       cfg_hit;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index) inside
      mpa_pkg::REG_POOL_SIZE, mpa_pkg::REG_STRIDE,
      mpa_pkg::REG_PLANE_HEIGHT, mpa_pkg::REG_PLANE_WIDTH: cfg_hit = cfg_valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size     <= mpa_pkg::POOL_RESET;
      stride       <= mpa_pkg::STRIDE_RESET;
      plane_height <= mpa_pkg::DIM_RESET;
      plane_width  <= mpa_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpa_pkg::REG_POOL_SIZE:    win_size     <= cfg_data[mpa_pkg::POOL_W-1:0];
        mpa_pkg::REG_STRIDE:       stride       <= cfg_data[mpa_pkg::POOL_W-1:0];
        mpa_pkg::REG_PLANE_HEIGHT: plane_height <= cfg_data;
        mpa_pkg::REG_PLANE_WIDTH:  plane_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective plane size: zero reads as one, large values saturate.
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  always_comb begin
    if (plane_width == '0)                   w_eff = (CW+1)'(1);
    else if (int'(plane_width) > MAX_WIDTH)  w_eff = (CW+1)'(MAX_WIDTH);
    else                                     w_eff = (CW+1)'(plane_width);
    if (plane_height == '0)                  h_eff = (RW+1)'(1);
    else if (int'(plane_height) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
    else                                     h_eff = (RW+1)'(plane_height);
  end

  logic pool_ok;
  assign pool_ok = (win_size != '0) && (int'(win_size) <= MAX_POOL) && (stride != '0);

  // Pipeline advance: the output register is free or being emptied.
  logic en, acc0;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc0     = s_tvalid && en;

  // Position counters. The stride phase and quotient track the window
  // origin incrementally, so no divider is needed.
  logic [CW-1:0]      col_count, col_q;
  logic [RW-1:0]      row_count, row_q;
  logic [3:0]         col_ph, row_ph;
  logic [SW-1:0]      slot;
  logic [mpa_pkg::PLANE_W-1:0] plane_count;
  logic               col_elig, row_elig, col_last, row_last, emit0;

  assign col_elig = ((CW+1)'(col_count) + (CW+1)'(1)) >= (CW+1)'(win_size);
  assign row_elig = ((RW+1)'(row_count) + (RW+1)'(1)) >= (RW+1)'(win_size);
  assign col_last = ((CW+1)'(col_count) + (CW+1)'(1)) == w_eff;
  assign row_last = ((RW+1)'(row_count) + (RW+1)'(1)) == h_eff;
  assign emit0    = pool_ok && col_elig && row_elig && (col_ph == '0) && (row_ph == '0);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
      col_ph    <= '0;
      col_q     <= '0;
      row_ph    <= '0;
      row_q     <= '0;
      slot      <= '0;
      if (rst) begin
        plane_count <= '0;
      end
    end else if (acc0) begin
      if (col_last) begin
        col_count <= '0;
        col_ph    <= '0;
        col_q     <= '0;
        if (row_last) begin
          row_count   <= '0;
          row_ph      <= '0;
          row_q       <= '0;
          slot        <= '0;
          plane_count <= plane_count + 1'b1;
        end else begin
          row_count <= row_count + 1'b1;
          slot      <= (int'(slot) == LINE_ROWS - 1) ? '0 : slot + 1'b1;
          if (!row_elig) begin
            row_ph <= '0;
            row_q  <= '0;
          end else if (row_ph + 1'b1 == stride) begin
            row_ph <= '0;
            row_q  <= row_q + 1'b1;
          end else begin
            row_ph <= row_ph + 1'b1;
          end
        end
      end else begin
        col_count <= col_count + 1'b1;
        if (!col_elig) begin
          col_ph <= '0;
          col_q  <= '0;
        end else if (col_ph + 1'b1 == stride) begin
          col_ph <= '0;
          col_q  <= col_q + 1'b1;
        end else begin
          col_ph <= col_ph + 1'b1;
        end
      end
    end
  end

  // Line store: one memory per buffered row, all read at the current column.
  logic [DW-1:0] line_rd [LINE_ROWS];
  logic signed [DW-1:0] pix0;
  assign pix0 = s_tdata[DW-1:0];

  for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
    mpa_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (acc0 && (int'(slot) == k)),
      .waddr (col_count),
      .wdata (pix0),
      .re    (en),
      .raddr (col_count),
      .rdata (line_rd[k])
    );
  end

  // Stage 1 registers.
  logic                 v1, emit1;
  logic signed [DW-1:0] pix1;
  logic [SW-1:0]        slot1;
  logic [RW-1:0]        r0_1, orow1;
  logic [CW-1:0]        c0_1, ocol1;
  logic [mpa_pkg::PLANE_W-1:0] plane1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= acc0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit1  <= emit0;
      pix1   <= pix0;
      slot1  <= slot;
      r0_1   <= RW'((RW+1)'(row_count) + (RW+1)'(1) - (RW+1)'(win_size));
      c0_1   <= CW'((CW+1)'(col_count) + (CW+1)'(1) - (CW+1)'(win_size));
      orow1  <= row_q;
      ocol1  <= col_q;
      plane1 <= plane_count;
    end
  end

  // Column reduction over the pool rows; earlier rows win ties.
  logic signed [DW-1:0] column [MAX_POOL];
  logic signed [DW-1:0] cbest;
  logic [PW-1:0]        cbest_d;

  always_comb begin
    int t;
    logic found;
    t       = 0;
    found   = 1'b0;
    cbest   = pix1;
    cbest_d = '0;
    column[0] = pix1;
    for (int d = 1; d < MAX_POOL; d++) begin
      t = int'(slot1) - (d % LINE_ROWS);
      if (t < 0) t = t + LINE_ROWS;
      column[d] = line_rd[SW'(t)];
    end
    for (int d = MAX_POOL - 1; d >= 0; d--) begin
      if ((d < int'(win_size)) && (!found || (column[d] > cbest))) begin
        found   = 1'b1;
        cbest   = column[d];
        cbest_d = PW'(d);
      end
    end
  end

  // Stage 2 registers.
  logic                 v2, emit2;
  logic signed [DW-1:0] val2;
  logic [PW-1:0]        d2;
  logic [RW-1:0]        r0_2, orow2;
  logic [CW-1:0]        c0_2, ocol2;
  logic [mpa_pkg::PLANE_W-1:0] plane2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit2  <= emit1;
      val2   <= cbest;
      d2     <= cbest_d;
      r0_2   <= r0_1;
      c0_2   <= c0_1;
      orow2  <= orow1;
      ocol2  <= ocol1;
      plane2 <= plane1;
    end
  end

  // Chain of column cells; cell 0 holds the newest column.
  logic signed [DW-1:0] cv  [MAX_POOL];
  logic [PW-1:0]        cr  [MAX_POOL];
  logic                 ah  [MAX_POOL+1];
  logic signed [DW-1:0] av  [MAX_POOL+1];
  logic [PW-1:0]        ar  [MAX_POOL+1];
  logic [PW-1:0]        ac  [MAX_POOL+1];

  assign ah[MAX_POOL] = 1'b0;
  assign av[MAX_POOL] = '0;
  assign ar[MAX_POOL] = '0;
  assign ac[MAX_POOL] = '0;

  for (genvar e = 0; e < MAX_POOL; e++) begin : g_cell
    mpa_cell #(.DW(DW), .PW(PW), .IDX(e)) u_cell (
      .clk         (clk),
      .shift       (v2 && en),
      .pool        (win_size),
      .in_val      ((e == 0) ? val2 : cv[(e == 0) ? 0 : e-1]),
      .in_row      ((e == 0) ? d2   : cr[(e == 0) ? 0 : e-1]),
      .val         (cv[e]),
      .row         (cr[e]),
      .acc_hit_in  (ah[e+1]),
      .acc_val_in  (av[e+1]),
      .acc_row_in  (ar[e+1]),
      .acc_col_in  (ac[e+1]),
      .acc_hit_out (ah[e]),
      .acc_val_out (av[e]),
      .acc_row_out (ar[e]),
      .acc_col_out (ac[e])
    );
  end

  // Stage 3 registers.
  logic          v3, emit3;
  logic [RW-1:0] r0_3, orow3;
  logic [CW-1:0] c0_3, ocol3;
  logic [mpa_pkg::PLANE_W-1:0] plane3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit3  <= emit2;
      r0_3   <= r0_2;
      c0_3   <= c0_2;
      orow3  <= orow2;
      ocol3  <= ocol2;
      plane3 <= plane2;
    end
  end

  // Output register.
  logic [PSW-1:0] arg_row, arg_col;
  assign arg_row = PSW'(int'(r0_3) + int'(win_size) - 1 - int'(ar[0]));
  assign arg_col = PSW'(int'(c0_3) + int'(win_size) - 1 - int'(ac[0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v3 && emit3;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v3 && emit3) begin
      m_tdata <= OTW'({PSW'(ocol3), PSW'(orow3), plane3, arg_col, arg_row, av[0]});
    end
  end

endmodule
`default_nettype wire
